// ===== rtl/gbcf_pkg.sv =====
`timescale 1ns / 1ps

package gbcf_pkg;

  localparam int SECTIONS    = 4;
  localparam int SEC_W       = $clog2(SECTIONS);
  localparam int SAMPLE_BITS = 24;
  localparam int SIG_W       = 48;
  localparam int COEF_W      = 48;
  localparam int SIG_FRAC    = 16;
  localparam int ACC_W       = 2 * COEF_W;
  localparam int PROD_SHIFT  = 40;
  localparam int HALF_W      = COEF_W / 2;
  localparam int RND_W       = SIG_W - SIG_FRAC + 1;
  localparam int SUM_W       = SIG_W + 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

  localparam logic signed [SIG_W-1:0] S48_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] S48_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  localparam logic signed [RND_W-1:0] OUT_MAX =
    {{(RND_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RND_W-1:0] OUT_MIN = ~OUT_MAX;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATER_B0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_S0_B1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_S1_B1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_S2_B1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_S3_B1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FB_A1    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FB_A2    = 3'd7;

  // multiply slots of one section
  typedef enum logic [1:0] {
    OP_B0X = 2'd0,
    OP_B1X = 2'd1,
    OP_A1Y = 2'd2,
    OP_A2Y = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;
  } out_t;

  typedef struct packed {
    logic             load;
    logic             mul_start;
    op_t              op;
    logic [SEC_W-1:0] sec;
    logic             apply;
    logic             final_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  function automatic logic signed [SIG_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic [2:0] top;
    top = v[SUM_W-1:SIG_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[SIG_W-1:0];
    end
    return v[SUM_W-1] ? S48_MIN : S48_MAX;
  endfunction

endpackage

// ===== rtl/gammatone_biquad_cascade_filter.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_data   (gbcf_pkg::in_t)
// out_     output     out_valid/ out_stall out_data  (gbcf_pkg::out_t)
// cfg_     input      cfg_we               cfg_index, cfg_wdata (8 coefficient registers)
//
// One request is accepted, runs 16 multiplies in turn on the shared
// 24x24 partial-product multiplier (4 partial products, accumulate, saturate),
// and is then rounded into the output register.
// Reset (rst_n low, synchronous) clears coefficients and section state at once.
// The output register frees the engine; a stall on out_ only holds a finished
// result in the round step, and in_stall is high while a request is in work.

module gammatone_biquad_cascade_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gbcf_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gbcf_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [gbcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbcf_pkg::COEF_W-1:0]       cfg_wdata
);

  gbcf_pkg::cmd_t  cmd;
  gbcf_pkg::stat_t stat;

  gbcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbcf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/gbcf_mul.sv =====
`timescale 1ns / 1ps

// signed 48x48 -> (p >> 40) rounded half away, saturated; one 24x24 product a cycle
module gbcf_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [gbcf_pkg::COEF_W-1:0]    coef,
  input  logic signed [gbcf_pkg::SIG_W-1:0]     sig,
  output logic signed [gbcf_pkg::SIG_W-1:0]     res,
  output gbcf_pkg::stat_t                       stat
);

  localparam int CW = gbcf_pkg::COEF_W;
  localparam int HW = gbcf_pkg::HALF_W;
  localparam int AW = gbcf_pkg::ACC_W;
  localparam int MW = AW - gbcf_pkg::PROD_SHIFT;

  localparam logic [2:0] PP_STEPS = 3'd4;
  localparam logic [2:0] CNT_LAST = 3'd5;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_48 = 2'd2;

  localparam logic [AW-1:0] RND_INIT = AW'(1) << (gbcf_pkg::PROD_SHIFT - 1);

  logic [CW-1:0]                 a_r, b_r;
  logic                          neg_r;
  logic [2:0]                    cnt_r;
  logic                          busy_r, done_r;
  logic [2*HW-1:0]               pp_r, pp_nxt;
  logic [1:0]                    sh_r, sh_nxt;
  logic                          ppv_r;
  logic [AW-1:0]                 acc_r, addend;
  logic signed [gbcf_pkg::SIG_W-1:0] res_r, res_nxt;
  logic [MW-1:0]                 mag;
  logic                          ovf;
  logic [HW-1:0]                 op_a, op_b;

  always_comb begin
    op_a   = a_r[HW-1:0];
    op_b   = b_r[HW-1:0];
    sh_nxt = SH_0;
    case (cnt_r[1:0])
      2'd0: begin
        op_a = a_r[HW-1:0];  op_b = b_r[HW-1:0];  sh_nxt = SH_0;
      end
      2'd1: begin
        op_a = a_r[HW-1:0];  op_b = b_r[CW-1:HW]; sh_nxt = SH_24;
      end
      2'd2: begin
        op_a = a_r[CW-1:HW]; op_b = b_r[HW-1:0];  sh_nxt = SH_24;
      end
      default: begin
        op_a = a_r[CW-1:HW]; op_b = b_r[CW-1:HW]; sh_nxt = SH_48;
      end
    endcase
    pp_nxt = op_a * op_b;
  end

  always_comb begin
    case (sh_r)
      SH_24:   addend = AW'(pp_r) << HW;
      SH_48:   addend = AW'(pp_r) << CW;
      default: addend = AW'(pp_r);
    endcase
  end

  assign mag = acc_r[AW-1:gbcf_pkg::PROD_SHIFT];
  assign ovf = |mag[MW-1:CW-1];

  always_comb begin
    if (neg_r) begin
      res_nxt = ovf ? gbcf_pkg::S48_MIN : -$signed(mag[CW-1:0]);
    end else begin
      res_nxt = ovf ? gbcf_pkg::S48_MAX : $signed(mag[CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      ppv_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        ppv_r  <= 1'b0;
      end else if (busy_r) begin
        ppv_r <= (cnt_r < PP_STEPS);
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= coef[CW-1] ? CW'(0) - coef : coef;
      b_r   <= sig[CW-1] ? CW'(0) - sig : sig;
      neg_r <= coef[CW-1] ^ sig[CW-1];
      acc_r <= RND_INIT;
    end else if (busy_r) begin
      pp_r <= pp_nxt;
      sh_r <= sh_nxt;
      if (ppv_r) begin
        acc_r <= acc_r + addend;
      end
      if (cnt_r == CNT_LAST) begin
        res_r <= res_nxt;
      end
    end
  end

  assign res       = res_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/gbcf_dp.sv =====
`timescale 1ns / 1ps

module gbcf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gbcf_pkg::cmd_t                      cmd,
  input  gbcf_pkg::in_t                       in_data,
  input  logic                                cfg_we,
  input  logic [gbcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbcf_pkg::COEF_W-1:0]         cfg_wdata,
  output gbcf_pkg::stat_t                     stat,
  output gbcf_pkg::out_t                      out_data
);

  localparam int SW = gbcf_pkg::SIG_W;
  localparam int UW = gbcf_pkg::SUM_W;
  localparam int RW = gbcf_pkg::RND_W;
  localparam int SB = gbcf_pkg::SAMPLE_BITS;

  logic signed [gbcf_pkg::COEF_W-1:0] first_b0_r, later_b0_r, a1_r, a2_r;
  logic signed [gbcf_pkg::COEF_W-1:0] b1_r [gbcf_pkg::SECTIONS];
  logic signed [SW-1:0] df_r [gbcf_pkg::SECTIONS];
  logic signed [SW-1:0] ds_r [gbcf_pkg::SECTIONS];
  logic signed [SW-1:0] x_r, y_r, p1_r;
  logic                 blk_r;
  gbcf_pkg::out_t       out_r;

  logic signed [gbcf_pkg::COEF_W-1:0] mul_coef;
  logic signed [SW-1:0] mul_sig, mul_res;
  logic signed [SW-1:0] df_sel, ds_sel;
  logic signed [UW-1:0] y_sum, df_sum, ds_sum;
  logic signed [SW:0]   rnd;
  logic signed [RW-1:0] q;
  logic signed [SB-1:0] q_sat;

  gbcf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .coef  (mul_coef),
    .sig   (mul_sig),
    .res   (mul_res),
    .stat  (stat)
  );

  always_comb begin
    mul_coef = a2_r;
    mul_sig  = y_r;
    case (cmd.op)
      gbcf_pkg::OP_B0X: begin
        mul_coef = (cmd.sec == '0) ? first_b0_r : later_b0_r;
        mul_sig  = x_r;
      end
      gbcf_pkg::OP_B1X: begin
        mul_coef = b1_r[cmd.sec];
        mul_sig  = x_r;
      end
      gbcf_pkg::OP_A1Y: begin
        mul_coef = a1_r;
        mul_sig  = y_r;
      end
      default: begin
        mul_coef = a2_r;
        mul_sig  = y_r;
      end
    endcase
  end

  assign df_sel = df_r[cmd.sec];
  assign ds_sel = ds_r[cmd.sec];
  assign y_sum  = UW'(mul_res) + UW'(df_sel);
  assign df_sum = UW'(p1_r) - UW'(mul_res) + UW'(ds_sel);
  assign ds_sum = UW'(0) - UW'(mul_res);

  // round to nearest integer, floor shift, clamp to sample range
  assign rnd = (SW+1)'(x_r) + (SW+1)'(1 << (gbcf_pkg::SIG_FRAC - 1));
  assign q   = rnd[SW:gbcf_pkg::SIG_FRAC];
  always_comb begin
    if (q > gbcf_pkg::OUT_MAX) begin
      q_sat = gbcf_pkg::OUT_MAX[SB-1:0];
    end else if (q < gbcf_pkg::OUT_MIN) begin
      q_sat = gbcf_pkg::OUT_MIN[SB-1:0];
    end else begin
      q_sat = q[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_b0_r <= '0;
      later_b0_r <= '0;
      a1_r       <= '0;
      a2_r       <= '0;
      for (int i = 0; i < gbcf_pkg::SECTIONS; i++) begin
        b1_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbcf_pkg::REG_FIRST_B0: first_b0_r <= cfg_wdata;
        gbcf_pkg::REG_LATER_B0: later_b0_r <= cfg_wdata;
        gbcf_pkg::REG_S0_B1:    b1_r[0]    <= cfg_wdata;
        gbcf_pkg::REG_S1_B1:    b1_r[1]    <= cfg_wdata;
        gbcf_pkg::REG_S2_B1:    b1_r[2]    <= cfg_wdata;
        gbcf_pkg::REG_S3_B1:    b1_r[3]    <= cfg_wdata;
        gbcf_pkg::REG_FB_A1:    a1_r       <= cfg_wdata;
        gbcf_pkg::REG_FB_A2:    a2_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbcf_pkg::SECTIONS; i++) begin
        df_r[i] <= '0;
        ds_r[i] <= '0;
      end
    end else if (cmd.apply) begin
      case (cmd.op)
        gbcf_pkg::OP_A1Y: df_r[cmd.sec] <= gbcf_pkg::sat48(df_sum);
        gbcf_pkg::OP_A2Y: ds_r[cmd.sec] <= gbcf_pkg::sat48(ds_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= SW'(in_data.sample_in) <<< gbcf_pkg::SIG_FRAC;
      blk_r <= in_data.block_end_in;
    end else if (cmd.apply) begin
      case (cmd.op)
        gbcf_pkg::OP_B0X: y_r  <= gbcf_pkg::sat48(y_sum);
        gbcf_pkg::OP_B1X: p1_r <= mul_res;
        gbcf_pkg::OP_A2Y: x_r  <= y_r;
        default: ;
      endcase
    end
    if (cmd.final_load) begin
      out_r.sample_out    <= q_sat;
      out_r.block_end_out <= blk_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/gbcf_ctrl.sv =====
`timescale 1ns / 1ps

module gbcf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  gbcf_pkg::stat_t stat,
  output gbcf_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_FINAL = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  gbcf_pkg::op_t               op_r, op_nxt;
  logic [gbcf_pkg::SEC_W-1:0]  sec_r, sec_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.load       = (state_r == ST_IDLE) && in_valid;
    cmd.mul_start  = (state_r == ST_ISSUE);
    cmd.apply      = (state_r == ST_WAIT) && stat.done;
    cmd.final_load = (state_r == ST_FINAL) && (!out_valid_r || !out_stall);
    cmd.op         = op_r;
    cmd.sec        = sec_r;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sec_nxt   = sec_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ISSUE;
          op_nxt    = gbcf_pkg::OP_B0X;
          sec_nxt   = '0;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (stat.done) begin
          if (op_r != gbcf_pkg::OP_A2Y) begin
            op_nxt    = gbcf_pkg::op_t'(op_r + 2'd1);
            state_nxt = ST_ISSUE;
          end else if (sec_r != gbcf_pkg::SEC_LAST) begin
            op_nxt    = gbcf_pkg::OP_B0X;
            sec_nxt   = sec_r + gbcf_pkg::SEC_W'(1);
            state_nxt = ST_ISSUE;
          end else begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.final_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= gbcf_pkg::OP_B0X;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !stat.busy && !stat.done)
    else $error("multiplier started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> state_r == ST_WAIT)
    else $error("multiplier result arrived outside wait state");

  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_ISSUE && op_r == gbcf_pkg::OP_B0X && sec_r == '0)
    else $error("request did not start at section zero");

  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.final_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished sample not presented");

endmodule

// ===== tb/gbcf_output_checker.sv =====
`timescale 1ns / 1ps

module gbcf_output_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  gbcf_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  gbcf_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [gbcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbcf_pkg::COEF_W-1:0]    cfg_wdata,
  output int                             fault_count,
  output int                             pending_results,
  output int                             checked_results
);
  import gbcf_pkg::*;

  localparam longint SIG_HI = (longint'(1) <<< 47) - 1;
  localparam longint SIG_LO = -SIG_HI - 1;
  localparam longint OUT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;

  longint first_b0, later_b0, fb_a1, fb_a2;
  longint sec_b1 [SECTIONS];
  longint dly_first [SECTIONS];
  longint dly_second [SECTIONS];

  out_t expected_samples [$];
  out_t want;

  initial begin
    fault_count = 0;
    checked_results = 0;
    pending_results = 0;
  end

  function automatic longint clamp48(longint v);
    if (v > SIG_HI) return SIG_HI;
    if (v < SIG_LO) return SIG_LO;
    return v;
  endfunction

  // Q8.40 x Q32.16 -> Q32.16, half away from zero, saturated
  function automatic longint scale_q40(longint c, longint s);
    logic signed [95:0] prod;
    logic [95:0] mag;
    logic [95:0] rounded;
    prod = c * s;
    mag = prod[95] ? -prod : prod;
    rounded = (mag + (96'd1 << 39)) >> 40;
    if (prod[95]) begin
      if (rounded >= (96'd1 << 47)) return SIG_LO;
      return -longint'(rounded[63:0]);
    end
    if (rounded > 96'(SIG_HI)) return SIG_HI;
    return longint'(rounded[63:0]);
  endfunction

  function automatic out_t run_cascade(in_t req);
    longint x, y, b0, r;
    out_t res;
    x = longint'(req.sample_in) <<< SIG_FRAC;
    for (int s = 0; s < SECTIONS; s++) begin
      b0 = (s == 0) ? first_b0 : later_b0;
      y = clamp48(scale_q40(b0, x) + dly_first[s]);
      dly_first[s] = clamp48(scale_q40(sec_b1[s], x) - scale_q40(fb_a1, y) + dly_second[s]);
      dly_second[s] = clamp48(-scale_q40(fb_a2, y));
      x = y;
    end
    r = (x + (longint'(1) <<< (SIG_FRAC - 1))) >>> SIG_FRAC;
    if (r > OUT_HI) r = OUT_HI;
    if (r < OUT_LO) r = OUT_LO;
    res.sample_out = r[SAMPLE_BITS-1:0];
    res.block_end_out = req.block_end_in;
    return res;
  endfunction

  task automatic note_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fault_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      first_b0 = 0;
      later_b0 = 0;
      fb_a1 = 0;
      fb_a2 = 0;
      for (int s = 0; s < SECTIONS; s++) begin
        sec_b1[s] = 0;
        dly_first[s] = 0;
        dly_second[s] = 0;
      end
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_B0: first_b0 = longint'($signed(cfg_wdata));
          REG_LATER_B0: later_b0 = longint'($signed(cfg_wdata));
          REG_S0_B1:    sec_b1[0] = longint'($signed(cfg_wdata));
          REG_S1_B1:    sec_b1[1] = longint'($signed(cfg_wdata));
          REG_S2_B1:    sec_b1[2] = longint'($signed(cfg_wdata));
          REG_S3_B1:    sec_b1[3] = longint'($signed(cfg_wdata));
          REG_FB_A1:    fb_a1 = longint'($signed(cfg_wdata));
          REG_FB_A2:    fb_a2 = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      // older result first, so a stray result never meets this edge's request
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          note_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          want = expected_samples.pop_front();
          checked_results++;
          if (out_data.sample_out !== want.sample_out)
            note_mismatch($sformatf("sample_out %0d, want %0d",
                                    out_data.sample_out, want.sample_out));
          if (out_data.block_end_out !== want.block_end_out)
            note_mismatch($sformatf("block_end_out %b, want %b",
                                    out_data.block_end_out, want.block_end_out));
        end
      end
      if (in_valid && !in_stall)
        expected_samples.insert(expected_samples.size(), run_cascade(in_data));
    end
    pending_results <= expected_samples.size();
  end

endmodule

// ===== tb/gammatone_biquad_cascade_filter_test.sv =====
`timescale 1ns / 1ps

module gammatone_biquad_cascade_filter_test;
  import gbcf_pkg::*;

  localparam int COEF_REGS = 8;
  localparam int PHASE_SEGMENTS = 5;
  localparam int SEGMENT_REQUESTS = 50;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  int fault_count;
  int pending_results;
  int checked_results;
  int requests_sent = 0;
  int settings_loaded = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  logic [COEF_W-1:0] coef_plan [COEF_REGS];

  gammatone_biquad_cascade_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gbcf_output_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fault_count     (fault_count),
    .pending_results (pending_results),
    .checked_results (checked_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #4_000_000;
    $display("FAIL gammatone_biquad_cascade_filter");
    $finish;
  end

  function automatic logic [COEF_W-1:0] q40(real v);
    return COEF_W'(longint'(v * 1099511627776.0));
  endfunction

  // uniform over +/- 2^(40 + int_bits)
  function automatic logic [COEF_W-1:0] rand_coef(int int_bits);
    longint raw;
    raw = {$urandom, $urandom};
    return COEF_W'(raw >>> (23 - int_bits));
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_BITS'($urandom);
      4, 5: return $signed(SAMPLE_BITS'($urandom)) >>> $urandom_range(4, 22);
      6: return SAMPLE_MAX;
      7: return SAMPLE_MIN;
      8: return '0;
      default: return SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
    endcase
  endfunction

  task automatic plan_uniform(logic [COEF_W-1:0] v);
    for (int i = 0; i < COEF_REGS; i++) coef_plan[i] = v;
  endtask

  task automatic plan_random();
    case ($urandom_range(0, 9))
      0: plan_uniform(S48_MAX);
      1: plan_uniform(S48_MIN);
      2, 3: for (int i = 0; i < COEF_REGS; i++) coef_plan[i] = rand_coef(7);
      default: begin
        coef_plan[REG_FIRST_B0] = rand_coef(0);
        coef_plan[REG_LATER_B0] = rand_coef(0);
        coef_plan[REG_S0_B1] = rand_coef(0);
        coef_plan[REG_S1_B1] = rand_coef(0);
        coef_plan[REG_S2_B1] = rand_coef(0);
        coef_plan[REG_S3_B1] = rand_coef(0);
        coef_plan[REG_FB_A1] = rand_coef(1);
        coef_plan[REG_FB_A2] = rand_coef(0);
      end
    endcase
  endtask

  task automatic program_coefs();
    for (int i = 0; i < COEF_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= coef_plan[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_request(logic signed [SAMPLE_BITS-1:0] smp, logic mark);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 150)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_in: smp, block_end_in: mark};
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // hold off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 33;
    stall_pct = 84;

    // unity pass-through
    plan_uniform('0);
    coef_plan[REG_FIRST_B0] = q40(1.0);
    coef_plan[REG_LATER_B0] = q40(1.0);
    program_coefs();
    send_request('0, 1'b0);
    send_request(SAMPLE_MAX, 1'b1);
    send_request(SAMPLE_MIN, 1'b0);
    send_request(SAMPLE_BITS'(1), 1'b0);
    send_request(-SAMPLE_BITS'(1), 1'b1);
    send_request(SAMPLE_BITS'('h555555), 1'b0);
    send_request(SAMPLE_BITS'('haaaaaa), 1'b1);

    // saturation at both coefficient extremes
    drain();
    plan_uniform(S48_MAX);
    program_coefs();
    send_request(SAMPLE_MAX, 1'b0);
    send_request(SAMPLE_MIN, 1'b1);
    send_request('0, 1'b0);
    send_request(SAMPLE_BITS'(1), 1'b0);
    drain();
    plan_uniform(S48_MIN);
    program_coefs();
    send_request(SAMPLE_MIN, 1'b0);
    send_request(SAMPLE_MAX, 1'b0);
    send_request(-SAMPLE_BITS'(1), 1'b1);
    send_request('0, 1'b0);

    // resonant cascade, impulse then ringing
    drain();
    coef_plan[REG_FIRST_B0] = q40(0.02);
    coef_plan[REG_LATER_B0] = q40(0.5);
    coef_plan[REG_S0_B1] = q40(0.3);
    coef_plan[REG_S1_B1] = q40(-0.25);
    coef_plan[REG_S2_B1] = q40(0.125);
    coef_plan[REG_S3_B1] = q40(-0.4);
    coef_plan[REG_FB_A1] = q40(-1.71);
    coef_plan[REG_FB_A2] = q40(0.9025);
    program_coefs();
    send_request(SAMPLE_BITS'(1 << 20), 1'b0);
    repeat (5) send_request('0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin idle_pct = 33; stall_pct = 84; end
        1: begin idle_pct = 84; stall_pct = 33; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int seg = 0; seg < PHASE_SEGMENTS; seg++) begin
        drain();
        plan_random();
        program_coefs();
        repeat (SEGMENT_REQUESTS) send_request(rand_sample(), ($urandom_range(0, 7) == 0));
      end
    end

    drain();
    repeat (140) @(posedge clk);
    $display("Sent %0d requests over %0d coefficient settings and three idle patterns;",
             requests_sent, settings_loaded);
    $display("%0d results compared, %0d mismatches.", checked_results, fault_count);
    if (fault_count == 0) begin
      $display("PASS gammatone_biquad_cascade_filter");
    end else begin
      $display("FAIL gammatone_biquad_cascade_filter");
    end
    $finish;
  end

endmodule

// ===== gammatone_biquad_cascade_filter.f =====
rtl/gbcf_pkg.sv
rtl/gbcf_mul.sv
rtl/gbcf_dp.sv
rtl/gbcf_ctrl.sv
rtl/gammatone_biquad_cascade_filter.sv
tb/gbcf_output_checker.sv
tb/gammatone_biquad_cascade_filter_test.sv
